// ----- rtl/qtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// qtpd_pkg: shared types, constants and sine table for the tone power detector
// Holds the fixed-point widths, the controller command and status structs,
// the operation codes and the quarter-wave sine table with its lookup.
// ----------------------------------------------------------------------------
package qtpd_pkg;

	// Widths of the interface fields and registers
	localparam int SAMPLE_WIDTH     = 24;
	localparam int COUNT_WIDTH      = 18;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int PHASE_W          = 32;
	localparam int GAIN_W           = 32;
	localparam int CFG_W            = 32;
	localparam int CFG_IDX_W        = 2;
	localparam int POWER_W          = 64;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(48000);

	// Datapath widths
	localparam int SINE_W  = 18;                // Q1.17 table value
	localparam int SUM_W   = 60;                // correlation sums
	localparam int HALF_W  = SUM_W / 2;         // multiplier chunk of a wide operand
	localparam int MUL_W   = 33;                // signed multiplier operand
	localparam int PROD_W  = 2 * MUL_W;
	localparam int T_W     = SUM_W + 2;         // scaled magnitude before the final shift
	localparam int PW_W    = 2 * SUM_W + 1;     // sum of the two squares
	localparam int POW_LSB = GAIN_W - 1;        // doubling then dropping 32 fraction bits

	// Sine table geometry
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int QTR   = SINE_TABLE_DEPTH / 4;

	// Multiplier operand selection
	localparam logic [2:0] MUL_NONE = 3'd0;
	localparam logic [2:0] MUL_SIN  = 3'd1;
	localparam logic [2:0] MUL_COS  = 3'd2;
	localparam logic [2:0] MUL_LO   = 3'd3;
	localparam logic [2:0] MUL_HI   = 3'd4;
	localparam logic [2:0] MUL_BB   = 3'd5;
	localparam logic [2:0] MUL_AB   = 3'd6;
	localparam logic [2:0] MUL_AA   = 3'd7;

	// Use of the registered product
	localparam logic [3:0] ACC_NONE = 4'd0;
	localparam logic [3:0] ACC_SIN  = 4'd1;
	localparam logic [3:0] ACC_COS  = 4'd2;
	localparam logic [3:0] ACC_ABS  = 4'd3;
	localparam logic [3:0] ACC_TLO  = 4'd4;
	localparam logic [3:0] ACC_THI  = 4'd5;
	localparam logic [3:0] ACC_PB   = 4'd6;
	localparam logic [3:0] ACC_PAB  = 4'd7;
	localparam logic [3:0] ACC_PAA  = 4'd8;

	typedef struct packed {
		logic       take;      // request accepted on the input channel
		logic [2:0] mul_op;
		logic [3:0] acc_op;
		logic       sel;       // 0: sine sum, 1: cosine sum
		logic       load_out;  // load power into the output register, clear the sums
	} cmd_t;

	typedef struct packed {
		logic last;      // the accepted sample closes a measurement
		logic out_free;  // output register can take a new result this cycle
	} status_t;

	// Table generation constants
	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam int              ANGLE_FRAC  = 30;
	localparam int              Q_SHIFT     = ANGLE_FRAC - (SINE_W - 1);
	localparam longint          Q_ROUND     = longint'(1) <<< (Q_SHIFT - 1);
	localparam longint          SINE_MAX    = (longint'(1) <<< (SINE_W - 1)) - 1;

	typedef logic [SINE_W-2:0] qtab_t [QTR];

	// Magnitude of the sine at quarter position j (j = QTR gives the peak).
	// Nine-term Taylor series in Q30 with truncated terms, rounded to Q17.
	function automatic logic [SINE_W-2:0] qsine(input longint unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint          v;
		x    = (PI_HALF_Q30 * (4 * j) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		x2   = (x * x) >> ANGLE_FRAC;
		term = x;
		acc  = longint'(x);
		term = ((term * x2) >> ANGLE_FRAC) / 6;
		acc  = acc - longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 20;
		acc  = acc + longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 42;
		acc  = acc - longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 72;
		acc  = acc + longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 110;
		acc  = acc - longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 156;
		acc  = acc + longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 210;
		acc  = acc - longint'(term);
		term = ((term * x2) >> ANGLE_FRAC) / 272;
		acc  = acc + longint'(term);
		if (acc < 0) begin
			acc = 0;
		end
		v = (acc + Q_ROUND) >>> Q_SHIFT;
		if (v > SINE_MAX) begin
			v = SINE_MAX;
		end
		return (SINE_W - 1)'(v);
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int j = 0; j < QTR; j++) begin
			t[j] = qsine(longint'(j));
		end
		return t;
	endfunction

	localparam qtab_t             QTAB      = build_qtab();
	localparam logic [SINE_W-2:0] SINE_PEAK = qsine(longint'(QTR));

	// Full-wave lookup from the quarter table. The second and fourth quarters
	// read the table mirrored; the start of those quarters is the peak itself.
	function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [IDX_W-1:0] idx);
		logic [1:0]        quad;
		logic [IDX_W-3:0]  pos;
		logic [IDX_W-3:0]  mir;
		logic [SINE_W-2:0] m;
		quad = idx[IDX_W-1 -: 2];
		pos  = idx[IDX_W-3:0];
		mir  = '0 - pos;
		if (quad[0]) begin
			m = (pos == '0) ? SINE_PEAK : QTAB[mir];
		end else begin
			m = QTAB[pos];
		end
		return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

// ----- rtl/qtpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// qtpd_ctrl: sequencer of the tone power detector
// Steps the shared multiplier through the two correlation products of each
// sample and, at the end of a measurement, through scaling and squaring.
// ----------------------------------------------------------------------------
module qtpd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  qtpd_pkg::status_t status,
	output qtpd_pkg::cmd_t    cmd
);
	import qtpd_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MSIN  = 4'd1;
	localparam logic [3:0] ST_MCOS  = 4'd2;
	localparam logic [3:0] ST_ACOS  = 4'd3;
	localparam logic [3:0] ST_ABS   = 4'd4;
	localparam logic [3:0] ST_MLO   = 4'd5;
	localparam logic [3:0] ST_MHI   = 4'd6;
	localparam logic [3:0] ST_TSUM  = 4'd7;
	localparam logic [3:0] ST_SQB   = 4'd8;
	localparam logic [3:0] ST_SQAB  = 4'd9;
	localparam logic [3:0] ST_SQA   = 4'd10;
	localparam logic [3:0] ST_SQEND = 4'd11;
	localparam logic [3:0] ST_FIN   = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       sel_q;
	logic       sel_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		sel_d        = sel_q;
		cmd.take     = 1'b0;
		cmd.mul_op   = MUL_NONE;
		cmd.acc_op   = ACC_NONE;
		cmd.sel      = sel_q;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) begin
					state_d = ST_MSIN;
				end
			end
			ST_MSIN: begin
				cmd.mul_op = MUL_SIN;
				state_d    = ST_MCOS;
			end
			ST_MCOS: begin
				cmd.mul_op = MUL_COS;
				cmd.acc_op = ACC_SIN;
				state_d    = ST_ACOS;
			end
			ST_ACOS: begin
				cmd.acc_op = ACC_COS;
				state_d    = status.last ? ST_ABS : ST_IDLE;
			end
			ST_ABS: begin
				cmd.acc_op = ACC_ABS;
				state_d    = ST_MLO;
			end
			ST_MLO: begin
				cmd.mul_op = MUL_LO;
				state_d    = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_op = MUL_HI;
				cmd.acc_op = ACC_TLO;
				state_d    = ST_TSUM;
			end
			ST_TSUM: begin
				cmd.acc_op = ACC_THI;
				state_d    = ST_SQB;
			end
			ST_SQB: begin
				cmd.mul_op = MUL_BB;
				state_d    = ST_SQAB;
			end
			ST_SQAB: begin
				cmd.mul_op = MUL_AB;
				cmd.acc_op = ACC_PB;
				state_d    = ST_SQA;
			end
			ST_SQA: begin
				cmd.mul_op = MUL_AA;
				cmd.acc_op = ACC_PAB;
				state_d    = ST_SQEND;
			end
			ST_SQEND: begin
				cmd.acc_op = ACC_PAA;
				if (sel_q) begin
					state_d = ST_FIN;
				end else begin
					sel_d   = 1'b1;
					state_d = ST_ABS;
				end
			end
			ST_FIN: begin
				// Hold here while the previous result is still waiting downstream.
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					sel_d        = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				sel_d   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free)
		else $error("result loaded while the output register is occupied");

	a_idle_on_sine: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sel_q)
		else $error("cosine select left set outside a measurement close");

	a_fin_after_squares: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> $past(state_q == ST_SQEND || state_q == ST_FIN))
		else $error("finish state reached without the cosine square");

endmodule

// ----- rtl/qtpd_datapath.sv -----
// ----------------------------------------------------------------------------
// qtpd_datapath: registers, shared multiplier and accumulators
// Keeps the phase, the two correlation sums and the sample counter, and runs
// one signed multiplier under control of the sequencer.
// ----------------------------------------------------------------------------
module qtpd_datapath (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [qtpd_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [qtpd_pkg::CFG_W-1:0]               cfg_data,
	input  logic signed [qtpd_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                     out_stall,
	output logic                                     out_valid,
	output logic [qtpd_pkg::POWER_W-1:0]             power,
	input  qtpd_pkg::cmd_t                           cmd,
	output qtpd_pkg::status_t                        status
);
	import qtpd_pkg::*;

	// Configuration
	logic [PHASE_W-1:0]     phase_step_q;
	logic [COUNT_WIDTH-1:0] sample_count_q;
	logic [GAIN_W-1:0]      gain_q;

	// Measurement state
	logic [PHASE_W-1:0]     phase_q;
	logic [SUM_W-1:0]       sine_sum_q;
	logic [SUM_W-1:0]       cosine_sum_q;
	logic [COUNT_WIDTH-1:0] samples_seen_q;
	logic                   last_q;
	logic                   out_valid_q;

	// Working registers
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SINE_W-1:0]       sin_q;
	logic signed [SINE_W-1:0]       cos_q;
	logic signed [PROD_W-1:0]       prod_q;
	logic [SUM_W-1:0]               mag_q;
	logic [T_W-1:0]                 t_q;
	logic [PW_W-1:0]                pw_q;
	logic [POWER_W-1:0]             power_q;

	logic [PHASE_W-1:0]       phase_nxt;
	logic [IDX_W-1:0]         sidx;
	logic [IDX_W-1:0]         cidx;
	logic [COUNT_WIDTH:0]     seen;
	logic                     last_d;
	logic signed [MUL_W-1:0]  a_op;
	logic signed [MUL_W-1:0]  b_op;
	logic signed [PROD_W-1:0] prod_d;
	logic [SUM_W-1:0]         abs_src;
	logic [SUM_W-1:0]         abs_val;
	logic [HALF_W-1:0]        sq_lo;
	logic [HALF_W-1:0]        sq_hi;
	logic [PW_W-1:0]          pw_prod;
	logic [POWER_W-1:0]       power_d;

	assign phase_nxt = phase_q + phase_step_q;
	assign sidx      = phase_q[PHASE_W-1 -: IDX_W];
	// The cosine reads a quarter turn ahead.
	assign cidx      = sidx + IDX_W'(QTR);
	assign seen      = {1'b0, samples_seen_q} + (COUNT_WIDTH + 1)'(1);
	assign last_d    = (seen >= {1'b0, sample_count_q});

	// Scaled magnitude split into two halves for squaring.
	assign sq_lo = t_q[HALF_W+1:2];
	assign sq_hi = t_q[SUM_W+1:HALF_W+2];

	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.mul_op)
			MUL_SIN: begin
				a_op = MUL_W'(sample_q);
				b_op = MUL_W'(sin_q);
			end
			MUL_COS: begin
				a_op = MUL_W'(sample_q);
				b_op = MUL_W'(cos_q);
			end
			MUL_LO: begin
				a_op = MUL_W'(mag_q[HALF_W-1:0]);
				b_op = MUL_W'(gain_q);
			end
			MUL_HI: begin
				a_op = MUL_W'(mag_q[SUM_W-1:HALF_W]);
				b_op = MUL_W'(gain_q);
			end
			MUL_BB: begin
				a_op = MUL_W'(sq_lo);
				b_op = MUL_W'(sq_lo);
			end
			MUL_AB: begin
				a_op = MUL_W'(sq_hi);
				b_op = MUL_W'(sq_lo);
			end
			MUL_AA: begin
				a_op = MUL_W'(sq_hi);
				b_op = MUL_W'(sq_hi);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod_d = a_op * b_op;

	assign abs_src = cmd.sel ? cosine_sum_q : sine_sum_q;
	assign abs_val = abs_src[SUM_W-1] ? (~abs_src + SUM_W'(1)) : abs_src;
	assign pw_prod = PW_W'(prod_q[2*HALF_W-1:0]);

	// Twice the sum of squares without the 32 fraction bits, saturating.
	assign power_d = (|pw_q[PW_W-1:POW_LSB+POWER_W]) ? '1 : pw_q[POW_LSB+POWER_W-1:POW_LSB];

	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign power           = power_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			sample_count_q <= COUNT_RESET;
			gain_q         <= '0;
			phase_q        <= '0;
			sine_sum_q     <= '0;
			cosine_sum_q   <= '0;
			samples_seen_q <= '0;
			last_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PHASE_STEP:   phase_step_q   <= cfg_data[PHASE_W-1:0];
					REG_SAMPLE_COUNT: sample_count_q <= cfg_data[COUNT_WIDTH-1:0];
					REG_GAIN:         gain_q         <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.take) begin
				phase_q        <= phase_nxt;
				last_q         <= last_d;
				samples_seen_q <= last_d ? '0 : seen[COUNT_WIDTH-1:0];
			end
			if (cmd.acc_op == ACC_SIN) begin
				sine_sum_q <= sine_sum_q + prod_q[SUM_W-1:0];
			end
			if (cmd.acc_op == ACC_COS) begin
				cosine_sum_q <= cosine_sum_q + prod_q[SUM_W-1:0];
			end
			if (cmd.load_out) begin
				sine_sum_q   <= '0;
				cosine_sum_q <= '0;
				out_valid_q  <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.take) begin
			sample_q <= sample;
			sin_q    <= sine_lookup(sidx);
			cos_q    <= sine_lookup(cidx);
		end
		case (cmd.acc_op)
			ACC_ABS: mag_q <= abs_val;
			ACC_TLO: t_q   <= T_W'(prod_q[HALF_W+GAIN_W-1:HALF_W]);
			ACC_THI: t_q   <= prod_q[T_W-1:0] + t_q;
			ACC_PB:  pw_q  <= (cmd.sel ? pw_q : '0) + pw_prod;
			ACC_PAB: pw_q  <= pw_q + (pw_prod << (HALF_W + 1));
			ACC_PAA: pw_q  <= pw_q + (pw_prod << (2 * HALF_W));
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			power_q <= power_d;
		end
	end

	a_phase_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (phase_q == $past(phase_nxt)))
		else $error("phase did not advance by one step per sample");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.load_out) |-> (sine_sum_q == '0 && cosine_sum_q == '0))
		else $error("correlation sums not cleared after a result");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

// ----- rtl/quadrature_tone_power_detector_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_tone_power_detector_unit: single-bin tone power detector
// Correlates audio samples with a sine and cosine of a free-running phase and
// reports the scaled power of the tone once per measurement.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    sample  (24-bit signed Q1.23)
//   output   out        out_valid / out_stall  power   (64-bit unsigned)
//   config   in         cfg_we                 cfg_index, cfg_data (32 bits)
//
// For each sample one multiplier forms the sine and the cosine product in
// turn, and each sum absorbs its product from the product register.
// For the sample that closes a measurement, each sum is then scaled in
// two multiplier passes and squared in three, then the result is loaded.
// Reset zeroes phase, sums, counter, step and gain; sample count gets 48000.
// While a result waits on out_stall, further samples are still taken; the
// next result waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
module quadrature_tone_power_detector_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [qtpd_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [qtpd_pkg::POWER_W-1:0]             power,
	input  logic                                     cfg_we,
	input  logic [qtpd_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [qtpd_pkg::CFG_W-1:0]               cfg_data
);
	import qtpd_pkg::*;

	cmd_t    cmd;
	status_t status;

	qtpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	qtpd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.power     (power),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ----- tb/qtpd_power_checker.sv -----
// ----------------------------------------------------------------------------
// qtpd_power_checker: prediction and comparison for the tone power detector
// Watches the sample, power and register channels. It keeps its own copy of
// the phase, the two correlation sums, the sample counter and the registers,
// and forms the expected power for every sample that closes a measurement.
// Each accepted power result is compared with the oldest expected value.
// ----------------------------------------------------------------------------
module qtpd_power_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_stall,
	input  logic signed [qtpd_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                     out_valid,
	input  logic                                     out_stall,
	input  logic [qtpd_pkg::POWER_W-1:0]             power,
	input  logic                                     cfg_we,
	input  logic [qtpd_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [qtpd_pkg::CFG_W-1:0]               cfg_data,
	output int                                       mismatches,
	output int                                       pending,
	output int                                       checked
);
	import qtpd_pkg::*;

	localparam int              ACC_W            = 60;
	localparam int              LUT_BITS         = $clog2(SINE_TABLE_DEPTH);
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	int                     wave_lut [SINE_TABLE_DEPTH];
	logic [31:0]            step_reg;
	logic [COUNT_WIDTH-1:0] count_reg;
	logic [31:0]            gain_reg;
	logic [31:0]            phase_acc;
	logic [ACC_W-1:0]       sin_acc;
	logic [ACC_W-1:0]       cos_acc;
	logic [COUNT_WIDTH-1:0] seen_reg;
	logic [POWER_W-1:0]     power_expected [$];

	// Full-wave sine value in Q1.17: the angle is folded into the first
	// quadrant, evaluated as a truncated Taylor series in Q30 and rounded.
	function automatic int wave_value(input int unsigned k);
		longint unsigned span;
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          acc;
		longint          mag;
		span = SINE_TABLE_DEPTH;
		quad = (4 * longint'(k)) / span;
		rem  = 4 * longint'(k) - quad * span;
		if (quad[0]) begin
			rem = span - rem;
		end
		x    = (QUARTER_TURN_Q30 * rem + span / 2) / span;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		mag = (acc + 4096) >>> 13;
		if (mag > 131071) begin
			mag = 131071;
		end
		return quad[1] ? -int'(mag) : int'(mag);
	endfunction

	// Magnitude of a sum times the gain, dropping 32 fraction bits.
	function automatic logic [ACC_W-1:0] scale_magnitude(input logic [ACC_W-1:0] sum,
							     input logic [31:0] g);
		logic [ACC_W-1:0]    mag;
		logic [ACC_W+31:0]   prod;
		mag  = sum[ACC_W-1] ? -sum : sum;
		prod = (ACC_W + 32)'(mag) * (ACC_W + 32)'(g);
		return prod[ACC_W+31:32];
	endfunction

	task automatic absorb_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
		longint             s_wide;
		longint             sin_prod;
		longint             cos_prod;
		logic [31:0]        cos_phase;
		logic [COUNT_WIDTH:0] next_seen;
		logic [ACC_W-1:0]   sin_mag;
		logic [ACC_W-1:0]   cos_mag;
		logic [127:0]       energy;
		s_wide    = longint'(smp);
		cos_phase = phase_acc + 32'h4000_0000;
		sin_prod  = s_wide * longint'(wave_lut[phase_acc[31 -: LUT_BITS]]);
		cos_prod  = s_wide * longint'(wave_lut[cos_phase[31 -: LUT_BITS]]);
		sin_acc   = sin_acc + sin_prod[ACC_W-1:0];
		cos_acc   = cos_acc + cos_prod[ACC_W-1:0];
		phase_acc = phase_acc + step_reg;
		next_seen = {1'b0, seen_reg} + 1'b1;
		// A count of zero, or one lowered below the samples already taken,
		// closes the measurement on this sample.
		if (next_seen < {1'b0, count_reg}) begin
			seen_reg = next_seen[COUNT_WIDTH-1:0];
		end else begin
			sin_mag = scale_magnitude(sin_acc, gain_reg);
			cos_mag = scale_magnitude(cos_acc, gain_reg);
			energy  = 128'(sin_mag) * 128'(sin_mag) + 128'(cos_mag) * 128'(cos_mag);
			if (energy[127:95] != '0) begin
				power_expected.push_back('1);
			end else begin
				power_expected.push_back(energy[94:31]);
			end
			sin_acc  = '0;
			cos_acc  = '0;
			seen_reg = '0;
		end
	endtask

	initial begin
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			wave_lut[k] = wave_value(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_reg   = '0;
			count_reg  = COUNT_WIDTH'(48000);
			gain_reg   = '0;
			phase_acc  = '0;
			sin_acc    = '0;
			cos_acc    = '0;
			seen_reg   = '0;
			mismatches = 0;
			checked    = 0;
			power_expected.delete();
		end else begin
			// Results first: a result never belongs to a sample taken at the same edge.
			if (out_valid && !out_stall) begin
				if (power_expected.size() == 0) begin
					$display("%0t: unexpected power result %h with nothing expected",
						 $time, power);
					mismatches++;
				end else begin
					if (power !== power_expected[0]) begin
						$display("%0t: power mismatch: expected %h, actual %h",
							 $time, power_expected[0], power);
						mismatches++;
					end
					void'(power_expected.pop_front());
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				absorb_sample(sample);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PHASE_STEP: begin
						step_reg = cfg_data[31:0];
					end
					REG_SAMPLE_COUNT: begin
						count_reg = cfg_data[COUNT_WIDTH-1:0];
					end
					REG_GAIN: begin
						gain_reg = cfg_data[31:0];
					end
					default: begin
					end
				endcase
			end
		end
		pending = power_expected.size();
	end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the quadrature tone power detector
// Drives samples and register writes into the detector, stalls the power
// output at random and once for a long stretch, and leaves prediction and
// comparison to the checker beside the block. A short directed opening covers
// the field extremes and the count corner cases, then random phases follow,
// each with its own register setting.
// ----------------------------------------------------------------------------
module tb_top;
	import qtpd_pkg::*;

	localparam int                            ITEM_TARGET  = 1950;
	localparam int                            SETTLE_WAIT  = 32;
	localparam int                            HOLD_CYCLES  = 400;
	localparam logic [CFG_IDX_W-1:0]          REG_UNUSED   = 2'd3;
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX  = 24'sh7F_FFFF;
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN  = 24'sh80_0000;
	localparam logic [COUNT_WIDTH-1:0]         COUNT_MAX   = '1;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample    = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [POWER_W-1:0]             power;
	logic                           cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]               cfg_data  = '0;

	int mismatches;
	int pending;
	int checked;
	int items_sent;
	int settings_used;
	bit calm;
	bit hold_req;
	bit hold_done;
	int hold_left;

	quadrature_tone_power_detector_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.power     (power),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	qtpd_power_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.power      (power),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked)
	);

	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("FAIL quadrature_tone_power_detector_unit");
		$finish;
	end

	// Power receiver: random stalls, a calm stretch, and one long hold-off.
	initial begin
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 24) begin
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one sample request and returns at the edge that accepts it.
	task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] value);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample   <= value;
		do begin
			@(posedge clk);
		end while (in_stall);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Stops offering and waits until the detector is idle, including a
	// sample still in flight that closes no measurement.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_WAIT) @(negedge clk);
		settings_used++;
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input bit loud);
		logic [31:0] r;
		r = $urandom();
		if (loud) begin
			return (r[31:28] != 0) ? SAMPLE_MAX : r[SAMPLE_WIDTH-1:0];
		end
		case (r[31:28])
			4'd0: return SAMPLE_MAX;
			4'd1: return SAMPLE_MIN;
			4'd2: return {{(SAMPLE_WIDTH - 5){r[4]}}, r[4:0]};
			default: return r[SAMPLE_WIDTH-1:0];
		endcase
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h4000_0000;
			3: return $urandom_range(1, 1 << 22);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 1 << 16);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 19))
			0: return 32'd0;
			1: return 32'(COUNT_MAX);
			2, 3, 4, 5, 6, 7: return $urandom_range(1, 4);
			default: return $urandom_range(5, 40);
		endcase
	endfunction

	initial begin
		int  phase_no;
		int  span;
		int  waited;
		bit  loud;
		items_sent    = 0;
		settings_used = 0;
		calm          = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset registers: zero gain and step, only the count shortened.
		write_reg(REG_SAMPLE_COUNT, 32'd4);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);
		push_sample('0);
		push_sample(-24'sd1);

		// Quarter-turn step at full gain, one result per sample.
		settle();
		write_reg(REG_PHASE_STEP, 32'h4000_0000);
		write_reg(REG_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_SAMPLE_COUNT, 32'd1);
		push_sample(SAMPLE_MAX);
		push_sample(SAMPLE_MIN);
		push_sample(24'sd1);
		push_sample(-24'sd1);
		push_sample(24'sh55_5555);
		push_sample(24'shAA_AAAA);

		// A count of zero behaves like a count of one.
		settle();
		write_reg(REG_SAMPLE_COUNT, 32'd0);
		push_sample(pick_sample(1'b0));
		push_sample(pick_sample(1'b0));

		// Largest count, then lowered below the samples already taken.
		settle();
		write_reg(REG_SAMPLE_COUNT, 32'(COUNT_MAX));
		repeat (5) push_sample(pick_sample(1'b0));
		settle();
		write_reg(REG_SAMPLE_COUNT, 32'd2);
		push_sample(pick_sample(1'b0));

		// Unused register index, full step, smallest nonzero gain.
		settle();
		write_reg(REG_UNUSED, $urandom());
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_GAIN, 32'd1);
		write_reg(REG_SAMPLE_COUNT, 32'd3);
		repeat (3) push_sample(pick_sample(1'b0));

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			calm = (phase_no >= 8 && phase_no < 11);
			loud = (phase_no != 2) && ($urandom_range(0, 19) == 0 || phase_no == 5);
			if (phase_no == 2) begin
				// Long output hold-off: one result per sample fills the detector.
				write_reg(REG_SAMPLE_COUNT, 32'd1);
				write_reg(REG_GAIN, pick_gain());
				span = 60;
			end else if (loud) begin
				// Sums large enough that the power saturates.
				write_reg(REG_PHASE_STEP, 32'd0);
				write_reg(REG_GAIN, 32'hF000_0000 | $urandom());
				write_reg(REG_SAMPLE_COUNT, $urandom_range(180, 260));
				span = $urandom_range(260, 280);
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					write_reg(REG_PHASE_STEP, pick_step());
				end
				if ($urandom_range(0, 3) != 0) begin
					write_reg(REG_GAIN, pick_gain());
				end
				if ($urandom_range(0, 3) != 0) begin
					write_reg(REG_SAMPLE_COUNT, pick_count());
				end
				if ($urandom_range(0, 5) == 0) begin
					write_reg(REG_UNUSED, $urandom());
				end
				span = $urandom_range(10, 80);
			end
			for (int j = 0; j < span; j++) begin
				push_sample(pick_sample(loud));
				if (phase_no == 2 && j == 0) begin
					hold_req = 1'b1;
				end
			end
			phase_no++;
		end

		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 200_000) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_WAIT) @(negedge clk);
		if (pending != 0) begin
			$display("%0t: %0d expected power results never arrived", $time, pending);
		end
		$display("Sent %0d samples across %0d register settings, with saturation,",
			 items_sent, settings_used + 1);
		$display("count corner cases and a long output hold-off; %0d results compared.",
			 checked);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS quadrature_tone_power_detector_unit");
		end else begin
			$display("FAIL quadrature_tone_power_detector_unit");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/qtpd_pkg.sv
rtl/qtpd_ctrl.sv
rtl/qtpd_datapath.sv
rtl/quadrature_tone_power_detector_unit.sv
tb/qtpd_power_checker.sv
tb/tb_top.sv
